// ===== rtl/fpdm_pkg.sv =====
// Package: shared types and constants of the frame phase drift monitor.
package fpdm_pkg;
  localparam int unsigned TsW = 48;
  localparam int unsigned PhW = 17;
  localparam int unsigned EntryW = 18;
  localparam logic [PhW-1:0] PhaseLimit = 17'd100000;
  localparam logic [19:0] UsPerSec = 20'd1000000;
  localparam logic [1:0] StrikeLimit = 2'd2;

  typedef enum logic [1:0] {
    ActVsync  = 2'd0,
    ActFinish = 2'd1,
    ActCheck  = 2'd2,
    ActResync = 2'd3
  } action_e;

  localparam logic [1:0] RegPclk   = 2'd0;
  localparam logic [1:0] RegLine   = 2'd1;
  localparam logic [1:0] RegFrame  = 2'd2;
  localparam logic [1:0] RegBounce = 2'd3;

  typedef struct packed {
    logic [1:0]     action;
    logic [TsW-1:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic           resync_now;
    logic           check_done;
    logic [PhW-1:0] median_phase_us;
    logic [15:0]    repair_count;
    logic [31:0]    frames_finished;
  } out_item_t;

  typedef struct packed {
    logic [26:0] pixel_clock_hz;
    logic [11:0] line_total_pixels;
    logic [11:0] frame_total_lines;
    logic [7:0]  bounce_rows;
  } cfg_t;

  // drift tolerance unit request / answer
  typedef struct packed {
    logic           start;
    logic [PhW-1:0] median;
    logic [PhW-1:0] baseline;
  } drift_req_t;

  typedef struct packed {
    logic done;
    logic out;
  } drift_rsp_t;
endpackage

// ===== rtl/fpdm_stream_if.sv =====
// Interface: valid/ready stream channel with a payload.
interface fpdm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fpdm_divider.sv =====
// Module: restoring unsigned divider, one quotient bit per cycle.
module fpdm_divider #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] num_i,
  input  logic [Width-1:0] den_i,
  output logic             done_o,
  output logic [Width-1:0] quo_o,
  output logic [Width-1:0] rem_o
);
  localparam int unsigned CntW = $clog2(Width + 1);
  logic [Width-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [Width:0]   trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0;
    trial = '0;
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i;
      cnt_d = CntW'(Width); busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, quo_q[Width-1]} - {1'b0, den_q};
      if (!trial[Width]) begin
        rem_d = trial[Width-1:0];
        quo_d = {quo_q[Width-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[Width-2:0], quo_q[Width-1]};
        quo_d = {quo_q[Width-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/fpdm_drift.sv =====
// Module: drift tolerance check against the baseline.
module fpdm_drift (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpdm_pkg::cfg_t      cfg_i,
  input  fpdm_pkg::drift_req_t req_i,
  output fpdm_pkg::drift_rsp_t rsp_o
);
  import fpdm_pkg::*;

  typedef enum logic [2:0] {
    SIdle, SLine, SMul, SMod, SFold
  } st_e;

  st_e st_q;
  logic        div_start;
  logic [31:0] div_num, div_den, div_quo, div_rem;
  logic        div_done;
  logic [31:0] line_us_q;
  logic [43:0] frame_us_q;
  logic [39:0] tol_q;
  logic signed [18:0] drift_q;
  logic        neg_q, mod_phase_q;
  logic        done_q, out_q;
  logic [26:0] clk_eff;
  logic [31:0] absd;
  logic signed [33:0] fold, half;
  logic [33:0] fold_abs;

  assign clk_eff = (cfg_i.pixel_clock_hz == '0) ? 27'd1 : cfg_i.pixel_clock_hz;

  fpdm_divider #(.Width(32)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem)
  );

  always_comb begin
    div_start = 1'b0;
    div_num = 32'(cfg_i.line_total_pixels) * 32'(UsPerSec);
    div_den = 32'(clk_eff);
    if (st_q == SIdle && req_i.start) div_start = 1'b1;
    if (st_q == SMul && mod_phase_q && frame_us_q != '0 && frame_us_q[43:32] == '0) begin
      div_start = 1'b1;
      div_num = absd;
      div_den = frame_us_q[31:0];
    end
  end

  assign absd = drift_q[18] ? 32'(-drift_q) : 32'(drift_q);
  assign half = 34'($signed({2'b0, frame_us_q[31:0] >> 1}));

  always_comb begin
    // signed remainder takes the sign of the dividend
    fold = neg_q ? -$signed({2'b0, div_rem}) : $signed({2'b0, div_rem});
    if (fold > half) fold = fold - $signed({2'b0, frame_us_q[31:0]});
    if (fold < -half) fold = fold + $signed({2'b0, frame_us_q[31:0]});
  end

  assign fold_abs = (fold < 0) ? 34'(-fold) : 34'(fold);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; done_q <= 1'b0; out_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (st_q)
        SIdle: if (req_i.start) begin
          drift_q <= $signed({2'b0, req_i.median}) - $signed({2'b0, req_i.baseline});
          st_q <= SLine;
        end
        SLine: if (div_done) begin
          line_us_q <= div_quo;
          st_q <= SMul;
          mod_phase_q <= 1'b0;
        end
        SMul: begin
          if (!mod_phase_q) begin
            frame_us_q <= 44'(line_us_q) * 44'(cfg_i.frame_total_lines);
            tol_q <= (40'(line_us_q) * 40'(cfg_i.bounce_rows)) >> 1;
            mod_phase_q <= 1'b1;
          end else begin
            neg_q <= drift_q[18];
            // a frame of 2^32 us or more never folds a drift below 2^17
            if (frame_us_q == '0 || frame_us_q[43:32] != '0) begin
              out_q <= 40'(absd) > tol_q; done_q <= 1'b1; st_q <= SIdle;
            end else st_q <= SMod;
          end
        end
        SMod: if (div_done) st_q <= SFold;
        SFold: begin
          out_q <= 40'(fold_abs) > tol_q;
          done_q <= 1'b1;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.out  = out_q;
endmodule

// ===== rtl/frame_phase_drift_monitor_top.sv =====
// Frame phase drift monitor: event sequencer, sample ring memory, median and drift check.
// Flow: vsync/finish/resync items pass through the SOut state to the result register; a check
//   poll reads the window, ranks it and, with the drift check, runs up to two divisions on one divider.
// Throughput: one item at a time; the ring RAM port and shared divider set the rate.
// Reset: asynchronous active low; counters, flags, state and config go to reset values;
//   data buffers are not cleared (ring memory read only after a full window is written).
module frame_phase_drift_monitor_top #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fpdm_stream_if.sink    in_if,
  fpdm_stream_if.source  out_if,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import fpdm_pkg::*;

  localparam int unsigned IdxW = $clog2(WINDOW_SIZE);
  localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);
  localparam logic [CntW-1:0] NeedValid = CntW'(WINDOW_SIZE / 2 + 1);

  typedef enum logic [2:0] {
    SIdle, SRead, SLoad, SSort, SDrift, SOut
  } st_e;

  cfg_t cfg_q;
  st_e  st_q;
  logic [EntryW-1:0] ring_mem [WINDOW_SIZE];
  logic [EntryW-1:0] rd_q;
  logic [IdxW-1:0]   rd_addr;
  logic [IdxW-1:0]   wr_ptr_q;
  logic [EntryW-1:0] vals_q [WINDOW_SIZE];
  logic [CntW-1:0]   n_q, ld_cnt_q, i_q;
  logic [TsW-1:0]    last_vs_q;
  logic              seen_q;
  logic [31:0]       total_q, mark_q, fin_q, diff;
  logic [PhW-1:0]    base_q, med_q;
  logic              known_q;
  logic [1:0]        strike_q;
  logic [15:0]       rep_q;
  out_item_t         res_q;
  logic              res_v_q;
  drift_req_t        dreq;
  drift_rsp_t        drsp;
  logic [TsW:0]      since;
  logic [EntryW-1:0] entry;
  logic              wr;
  logic [CntW-1:0]   rank;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      RegPclk:   prdata = 32'(cfg_q.pixel_clock_hz);
      RegLine:   prdata = 32'(cfg_q.line_total_pixels);
      RegFrame:  prdata = 32'(cfg_q.frame_total_lines);
      RegBounce: prdata = 32'(cfg_q.bounce_rows);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{27'd16000000, 12'd520, 12'd500, 8'd20};
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegPclk:   cfg_q.pixel_clock_hz    <= pwdata[26:0];
        RegLine:   cfg_q.line_total_pixels <= pwdata[11:0];
        RegFrame:  cfg_q.frame_total_lines <= pwdata[11:0];
        RegBounce: cfg_q.bounce_rows       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready   = (st_q == SIdle) && !res_v_q;
  assign out_if.valid  = res_v_q;
  assign out_if.data   = res_q;
  assign diff = total_q - mark_q;

  assign since = {1'b0, in_if.data.timestamp_us} - {1'b0, last_vs_q};
  assign entry = (seen_q && !since[TsW] && since < (TsW+1)'(PhaseLimit))
               ? {1'b0, since[PhW-1:0]} : {1'b1, {PhW{1'b0}}};
  assign wr = in_if.valid && in_if.ready && in_if.data.action == ActFinish;
  assign rd_addr = ld_cnt_q[IdxW-1:0];

  // ring memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr) ring_mem[wr_ptr_q] <= entry;
    rd_q <= ring_mem[rd_addr];
  end

  fpdm_drift u_drift (.clk_i, .rst_ni, .cfg_i(cfg_q), .req_i(dreq), .rsp_o(drsp));

  assign dreq.start = (st_q == SSort) && (n_q >= NeedValid) && (i_q == n_q) && known_q;
  assign dreq.median = med_q;
  assign dreq.baseline = base_q;

  // rank of candidate i: count of smaller values plus equal ones before it
  always_comb begin
    rank = '0;
    for (int k = 0; k < WINDOW_SIZE; k++) begin
      if (CntW'(k) < n_q && i_q < n_q) begin
        if (vals_q[k][PhW-1:0] < vals_q[i_q[IdxW-1:0]][PhW-1:0] ||
            (vals_q[k][PhW-1:0] == vals_q[i_q[IdxW-1:0]][PhW-1:0] &&
             CntW'(k) < i_q))
          rank = rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; last_vs_q <= '0; seen_q <= 1'b0; total_q <= '0;
      mark_q <= '0; fin_q <= '0; base_q <= '0; known_q <= 1'b0;
      strike_q <= '0; rep_q <= '0; res_v_q <= 1'b0;
      n_q <= '0; ld_cnt_q <= '0; i_q <= '0; med_q <= '0; wr_ptr_q <= '0;
    end else begin
      if (out_if.valid && out_if.ready) res_v_q <= 1'b0;
      unique case (st_q)
        SIdle: if (in_if.valid && in_if.ready) begin
          res_q.resync_now <= 1'b0;
          res_q.check_done <= 1'b0;
          res_q.median_phase_us <= '0;
          unique case (action_e'(in_if.data.action))
            ActVsync: begin
              last_vs_q <= in_if.data.timestamp_us; seen_q <= 1'b1; st_q <= SOut;
            end
            ActFinish: begin
              fin_q <= fin_q + 1'b1; total_q <= total_q + 1'b1; st_q <= SOut;
              wr_ptr_q <= (wr_ptr_q == IdxW'(WINDOW_SIZE - 1)) ? '0 : wr_ptr_q + 1'b1;
            end
            ActCheck: begin
              if (!diff[31] && diff >= 32'(WINDOW_SIZE)) begin
                mark_q <= total_q; ld_cnt_q <= '0; n_q <= '0; st_q <= SRead;
              end else st_q <= SOut;
            end
            ActResync: begin
              mark_q <= total_q + 32'd2; known_q <= 1'b0; strike_q <= '0;
              st_q <= SOut;
            end
            default: st_q <= SOut;
          endcase
        end
        SRead: begin
          ld_cnt_q <= ld_cnt_q + 1'b1;
          st_q <= SLoad;
        end
        SLoad: begin
          if (!rd_q[PhW]) begin
            vals_q[n_q[IdxW-1:0]] <= rd_q; n_q <= n_q + 1'b1;
          end
          if (ld_cnt_q == CntW'(WINDOW_SIZE)) begin
            i_q <= '0; st_q <= SSort;
          end else begin
            ld_cnt_q <= ld_cnt_q + 1'b1;
          end
        end
        SSort: begin
          if (n_q < NeedValid) st_q <= SOut;
          else if (i_q != n_q) begin
            if (rank == (n_q >> 1)) med_q <= vals_q[i_q[IdxW-1:0]][PhW-1:0];
            i_q <= i_q + 1'b1;
          end else begin
            res_q.check_done <= 1'b1;
            res_q.median_phase_us <= med_q;
            if (!known_q) begin
              base_q <= med_q; known_q <= 1'b1; st_q <= SOut;
            end else st_q <= SDrift;
          end
        end
        SDrift: if (drsp.done) begin
          if (!drsp.out) strike_q <= '0;
          else if (strike_q + 2'd1 >= StrikeLimit) begin
            if (rep_q != 16'hFFFF) rep_q <= rep_q + 1'b1;
            mark_q <= total_q + 32'd2; known_q <= 1'b0; strike_q <= '0;
            res_q.resync_now <= 1'b1;
          end else strike_q <= strike_q + 2'd1;
          st_q <= SOut;
        end
        SOut: begin
          res_v_q <= 1'b1;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
      if (st_q == SOut) begin
        res_q.repair_count <= rep_q;
        res_q.frames_finished <= fin_q;
      end
    end
  end
endmodule
